>>> rtl/dkes_pkg.sv
// Package for the date-keyed exchange sort unit.
// Record layout, sequencer states, emit strobe bundle and size defaults.
// No dependencies.
`default_nettype none
package dkes_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_W           = 21;
  localparam int REC_W           = 37;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] tag;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_I_RD,
    ST_I_LD,
    ST_J_RD,
    ST_J_CMP,
    ST_I_WB,
    ST_E_RD,
    ST_E_OUT
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic overflow;
  } emit_t;

  // Date key: year, then month, then day.
  function automatic logic [KEY_W-1:0] date_key(input rec_t r);
    date_key = {r.year, r.month, r.day};
  endfunction

endpackage
`default_nettype wire

>>> rtl/dkes_store.sv
// Record store: single write port, single registered read port.
// Depends on dkes_pkg (rec_t).
`default_nettype none
module dkes_store
  import dkes_pkg::*;
#(
  parameter int DEPTH = MAX_RECORDS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire rec_t          wdata,
  input  wire logic [AW-1:0] raddr,
  output rec_t               rdata
);

  rec_t mem [DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/dkes_cmp.sv
// Shared compare unit: flags a swap when the held record's date is older
// than the candidate's. Depends on dkes_pkg (rec_t, date_key).
`default_nettype none
module dkes_cmp
  import dkes_pkg::*;
(
  input  wire rec_t  held,
  input  wire rec_t  cand,
  output logic       swap
);

  assign swap = date_key(held) < date_key(cand);

endmodule
`default_nettype wire

>>> rtl/dkes_seq.sv
// Sequencer: loads records, runs the exchange sort through the store and
// the compare unit, then walks the store for output. Depends on dkes_pkg.
`default_nettype none
module dkes_seq
  import dkes_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  localparam int AW         = $clog2(MAX_RECORDS),
  localparam int CW         = $clog2(MAX_RECORDS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire rec_t          in_rec,
  input  wire logic          in_last,
  output logic               busy,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output rec_t               mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  wire rec_t          mem_rdata,
  output rec_t               held,
  input  wire logic          swap,
  output emit_t              emit
);

  seq_state_t     state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           drop_r, drop_nxt;
  logic [AW-1:0]  last_idx_r, last_idx_nxt;
  logic [AW-1:0]  i_r, i_nxt;
  logic [AW-1:0]  j_r, j_nxt;
  logic [AW-1:0]  k_r, k_nxt;
  rec_t           cur_r, cur_nxt;

  logic           acc;
  logic           full;
  logic [AW-1:0]  load_last_idx;
  logic           i_done;
  logic           j_done;
  logic           k_done;

  assign acc           = start && (state_r == ST_IDLE);
  assign full          = (cnt_r == CW'(MAX_RECORDS));
  assign load_last_idx = full ? AW'(MAX_RECORDS - 1) : cnt_r[AW-1:0];
  assign i_done        = ((i_r + AW'(1)) == last_idx_r);
  assign j_done        = (j_r == last_idx_r);
  assign k_done        = (k_r == last_idx_r);
  assign busy          = (state_r != ST_IDLE);
  assign held          = cur_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_last) begin
          state_nxt = (load_last_idx == '0) ? ST_E_RD : ST_I_RD;
        end
      end
      ST_I_RD:  state_nxt = ST_I_LD;
      ST_I_LD:  state_nxt = ST_J_RD;
      ST_J_RD:  state_nxt = ST_J_CMP;
      ST_J_CMP: state_nxt = j_done ? ST_I_WB : ST_J_RD;
      ST_I_WB:  state_nxt = i_done ? ST_E_RD : ST_I_RD;
      ST_E_RD:  state_nxt = ST_E_OUT;
      ST_E_OUT: state_nxt = k_done ? ST_IDLE : ST_E_RD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // store port and emit strobe
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_r;
    mem_wdata = cur_r;
    mem_raddr = i_r;
    emit      = '0;
    case (state_r)
      ST_IDLE: begin
        mem_we    = acc && !full;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = in_rec;
      end
      ST_J_RD:  mem_raddr = j_r;
      ST_J_CMP: begin
        mem_we    = swap;
        mem_waddr = j_r;
      end
      ST_I_WB:  mem_we = 1'b1;
      ST_E_RD:  mem_raddr = k_r;
      ST_E_OUT: begin
        emit.valid    = 1'b1;
        emit.last     = k_done;
        emit.overflow = drop_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt      = cnt_r;
    drop_nxt     = drop_r;
    last_idx_nxt = last_idx_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    cur_nxt      = cur_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
          last_idx_nxt = load_last_idx;
          i_nxt        = '0;
          k_nxt        = '0;
        end
      end
      ST_I_LD: begin
        cur_nxt = mem_rdata;
        j_nxt   = i_r + AW'(1);
      end
      ST_J_CMP: begin
        if (swap) begin
          cur_nxt = mem_rdata;
        end
        j_nxt = j_r + AW'(1);
      end
      ST_I_WB: begin
        i_nxt = i_r + AW'(1);
        k_nxt = '0;
      end
      ST_E_OUT: begin
        k_nxt = k_r + AW'(1);
        if (k_done) begin
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_idx_r <= last_idx_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    cur_r      <= cur_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RECORDS))
    else $error("record count above capacity");

  a_j_after_i: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_J_CMP) |-> (j_r > i_r && j_r <= last_idx_r))
    else $error("inner index out of range");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_E_RD || state_r == ST_E_OUT) |-> !mem_we)
    else $error("store written during output");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid && emit.last |=> (cnt_r == '0 && !drop_r && state_r == ST_IDLE))
    else $error("set not cleared after final transfer");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> busy)
    else $error("final record did not start the sort");

endmodule
`default_nettype wire

>>> rtl/date_key_exchange_sort_unit.sv
// Date-keyed exchange sort unit, newest first.
//
// Input: a record transfers at a clock edge with start high and busy low.
// Records load one per cycle into the store until one with in_last_record
// set. Up to MAX_RECORDS are kept; later ones are dropped and out_overflow
// is raised on every result of that set.
// Once the final record is taken, busy stays high while the set is sorted
// by exchange: position i is held in a register and compared against each
// later position j through one compare unit and one store port.
// Output then walks the store one record at a time: each result is on the
// out_ ports for one cycle with out_valid high, out_last marks the final
// one. The receiver cannot stall; results must be taken as they appear.
// busy drops in the cycle the final result appears.
// Reset (rst_n low, synchronous) empties the loader and clears the drop
// flag; the store contents are left as they are.
// Depends on dkes_pkg, dkes_store, dkes_cmp, dkes_seq.
`default_nettype none
module date_key_exchange_sort_unit
  import dkes_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [11:0] in_year,
  input  wire logic [3:0]  in_month,
  input  wire logic [4:0]  in_day,
  input  wire logic [15:0] in_tag,
  input  wire logic        in_last_record,
  output logic             out_valid,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [15:0]      out_tag,
  output logic             out_last,
  output logic             out_overflow
);

  localparam int AW = $clog2(MAX_RECORDS);

  rec_t          in_rec;
  rec_t          mem_wdata, mem_rdata, held;
  logic          mem_we, swap;
  logic [AW-1:0] mem_waddr, mem_raddr;
  emit_t         emit;

  logic          valid_r;
  logic          last_r;
  logic          ovf_r;
  rec_t          out_rec_r;

  assign in_rec = '{year: in_year, month: in_month, day: in_day, tag: in_tag};

  dkes_store #(.DEPTH(MAX_RECORDS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dkes_cmp u_cmp (
    .held (held),
    .cand (mem_rdata),
    .swap (swap)
  );

  dkes_seq #(.MAX_RECORDS(MAX_RECORDS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_rec    (in_rec),
    .in_last   (in_last_record),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .held      (held),
    .swap      (swap),
    .emit      (emit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_rec_r <= mem_rdata;
      last_r    <= emit.last;
      ovf_r     <= emit.overflow;
    end
  end

  assign out_valid    = valid_r;
  assign out_year     = out_rec_r.year;
  assign out_month    = out_rec_r.month;
  assign out_day      = out_rec_r.day;
  assign out_tag      = out_rec_r.tag;
  assign out_last     = last_r;
  assign out_overflow = ovf_r;

endmodule
`default_nettype wire
